### hdl/tdt_pkg.sv
// Shared types and constants for the tile deduplication table.
package tdt_pkg;

    localparam int BANK_W  = 2;
    localparam int ROW_W   = 32;
    localparam int ROWS    = 8;
    localparam int TILE_W  = ROW_W * ROWS;
    localparam int IDX_OUT_W  = 8;
    localparam int SLOT_OUT_W = 8;
    localparam int UCNT_OUT_W = 9;
    localparam int STAT_W  = 2;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    localparam logic [STAT_W-1:0] ST_MATCH = 2'd0;
    localparam logic [STAT_W-1:0] ST_NEW   = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic              oor;
        logic [BANK_W-1:0] bank;
        logic [TILE_W-1:0] tile;
    } t_item;

endpackage

### hdl/tile_dedup_table_top.sv
// Top level of the tile deduplication table: front queue plus search/store back end.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------------
//  item in  | start && !busy       | i_bank, i_row0 .. i_row7
//  result   | o_strobe (one cycle) | o_tile_index, o_status, o_map_slot, o_unique_count
//
//  An item is compared in the back end against the tiles stored in its bank until a match
//  or the last one (one stored tile compared per cycle, one memory read port); the result
//  is registered. Bad bank numbers and empty banks finish in the dequeue cycle.
//  Synchronous active-low reset clears counts, map positions and the queue;
//  the tile store itself is not cleared. busy rises when the two-entry queue
//  is full. The receiver cannot stall; each result is shown for one cycle.
module tile_dedup_table_top #(
    parameter int BANKS          = 3,
    parameter int TILES_PER_BANK = 256,
    parameter int MAP_PER_BANK   = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [tdt_pkg::BANK_W-1:0]     i_bank,
    input  logic [tdt_pkg::ROW_W-1:0]      i_row0,
    input  logic [tdt_pkg::ROW_W-1:0]      i_row1,
    input  logic [tdt_pkg::ROW_W-1:0]      i_row2,
    input  logic [tdt_pkg::ROW_W-1:0]      i_row3,
    input  logic [tdt_pkg::ROW_W-1:0]      i_row4,
    input  logic [tdt_pkg::ROW_W-1:0]      i_row5,
    input  logic [tdt_pkg::ROW_W-1:0]      i_row6,
    input  logic [tdt_pkg::ROW_W-1:0]      i_row7,
    output logic                           o_strobe,
    output logic [tdt_pkg::IDX_OUT_W-1:0]  o_tile_index,
    output logic [tdt_pkg::STAT_W-1:0]     o_status,
    output logic [tdt_pkg::SLOT_OUT_W-1:0] o_map_slot,
    output logic [tdt_pkg::UCNT_OUT_W-1:0] o_unique_count
);

    logic [tdt_pkg::TILE_W-1:0] tile;
    logic                       q_valid;
    tdt_pkg::t_item             q_item;
    logic                       q_pop;

    assign tile = {i_row7, i_row6, i_row5, i_row4, i_row3, i_row2, i_row1, i_row0};

    tdt_front #(
        .BANKS (BANKS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_bank  (i_bank),
        .i_tile  (tile),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    tdt_back #(
        .BANKS          (BANKS),
        .TILES_PER_BANK (TILES_PER_BANK),
        .MAP_PER_BANK   (MAP_PER_BANK)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (q_valid),
        .i_item         (q_item),
        .o_pop          (q_pop),
        .o_strobe       (o_strobe),
        .o_tile_index   (o_tile_index),
        .o_status       (o_status),
        .o_map_slot     (o_map_slot),
        .o_unique_count (o_unique_count)
    );

endmodule

### hdl/tdt_front.sv
// Front end: accepts items, flags bad bank numbers, holds them in a short queue.
module tdt_front #(
    parameter int BANKS = 3
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [tdt_pkg::BANK_W-1:0] i_bank,
    input  logic [tdt_pkg::TILE_W-1:0] i_tile,
    output logic                       o_valid,
    output tdt_pkg::t_item             o_item,
    input  logic                       i_pop
);

    tdt_pkg::t_item                  r_slot [tdt_pkg::Q_DEPTH];
    logic [tdt_pkg::Q_PTR_W-1:0]     r_wr_ptr;
    logic [tdt_pkg::Q_PTR_W-1:0]     r_rd_ptr;
    logic [tdt_pkg::Q_CNT_W-1:0]     r_cnt;
    logic                            push;
    logic                            pop;
    tdt_pkg::t_item                  n_item;

    assign busy    = (r_cnt == tdt_pkg::Q_CNT_W'(tdt_pkg::Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_slot[r_rd_ptr];
    assign push    = start && !busy;
    assign pop     = i_pop && o_valid;

    always_comb begin
        n_item.oor  = !(int'(i_bank) < BANKS);
        n_item.bank = i_bank;
        n_item.tile = i_tile;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### hdl/tdt_back.sv
// Back end: per-bank tile store, sequential search, insert and result register.
module tdt_back #(
    parameter int BANKS          = 3,
    parameter int TILES_PER_BANK = 256,
    parameter int MAP_PER_BANK   = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  tdt_pkg::t_item                 i_item,
    output logic                           o_pop,
    output logic                           o_strobe,
    output logic [tdt_pkg::IDX_OUT_W-1:0]  o_tile_index,
    output logic [tdt_pkg::STAT_W-1:0]     o_status,
    output logic [tdt_pkg::SLOT_OUT_W-1:0] o_map_slot,
    output logic [tdt_pkg::UCNT_OUT_W-1:0] o_unique_count
);

    localparam int BI_W   = (BANKS > 1) ? $clog2(BANKS) : 1;
    localparam int IDX_W  = $clog2(TILES_PER_BANK);
    localparam int CNT_W  = $clog2(TILES_PER_BANK + 1);
    localparam int MAP_W  = $clog2(MAP_PER_BANK);
    localparam int DEPTH  = BANKS * TILES_PER_BANK;
    localparam int ADDR_W = $clog2(DEPTH);

    typedef enum logic {S_IDLE, S_SEARCH} t_state;

    logic [tdt_pkg::TILE_W-1:0] mem [DEPTH];
    logic [tdt_pkg::TILE_W-1:0] r_rd_data;

    t_state                     r_state;
    logic [BI_W-1:0]            r_bank_idx;
    logic [tdt_pkg::TILE_W-1:0] r_tile;
    logic [ADDR_W-1:0]          r_base;
    logic [CNT_W-1:0]           r_cnt;
    logic [IDX_W-1:0]           r_cmp_idx;
    logic [CNT_W-1:0]           r_count [BANKS];
    logic [MAP_W-1:0]           r_map   [BANKS];

    logic                              r_strobe;
    logic [tdt_pkg::IDX_OUT_W-1:0]     r_tile_index;
    logic [tdt_pkg::STAT_W-1:0]        r_status;
    logic [tdt_pkg::SLOT_OUT_W-1:0]    r_map_slot;
    logic [tdt_pkg::UCNT_OUT_W-1:0]    r_unique_count;

    logic [BI_W-1:0]            head_bank;
    logic [ADDR_W-1:0]          head_base;
    logic [CNT_W-1:0]           head_cnt;
    logic [BI_W-1:0]            sel_bank;
    logic [MAP_W-1:0]           map_cur;
    logic [MAP_W-1:0]           map_nxt;
    logic                       cmp_hit;
    logic                       cmp_last;
    logic                       pop;
    logic                       rd_en;
    logic [ADDR_W-1:0]          rd_addr;
    logic                       wr_en;
    logic [ADDR_W-1:0]          wr_addr;
    logic [tdt_pkg::TILE_W-1:0] wr_data;

    assign o_pop          = pop;
    assign o_strobe       = r_strobe;
    assign o_tile_index   = r_tile_index;
    assign o_status       = r_status;
    assign o_map_slot     = r_map_slot;
    assign o_unique_count = r_unique_count;

    always_comb begin
        head_bank = BI_W'(i_item.bank);
        head_base = ADDR_W'(head_bank) * ADDR_W'(TILES_PER_BANK);
        head_cnt  = r_count[head_bank];
        pop       = (r_state == S_IDLE) && i_valid;
        sel_bank  = (r_state == S_IDLE) ? head_bank : r_bank_idx;
        map_cur   = r_map[sel_bank];
        map_nxt   = (map_cur == MAP_W'(MAP_PER_BANK - 1)) ? '0 : map_cur + 1'b1;
        cmp_hit   = (r_rd_data == r_tile);
        cmp_last  = ((CNT_W'(r_cmp_idx) + CNT_W'(1)) == r_cnt);

        rd_en   = 1'b0;
        rd_addr = head_base;
        wr_en   = 1'b0;
        wr_addr = head_base;
        wr_data = i_item.tile;
        unique case (r_state)
            S_IDLE: begin
                if (pop && !i_item.oor) begin
                    if (head_cnt != '0) begin
                        rd_en = 1'b1;
                    end else begin
                        wr_en = 1'b1;
                    end
                end
            end
            S_SEARCH: begin
                rd_addr = r_base + ADDR_W'(r_cmp_idx) + ADDR_W'(1);
                wr_addr = r_base + ADDR_W'(r_cnt);
                wr_data = r_tile;
                if (!cmp_hit && !cmp_last) begin
                    rd_en = 1'b1;
                end
                if (!cmp_hit && cmp_last && (r_cnt != CNT_W'(TILES_PER_BANK))) begin
                    wr_en = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            for (int b = 0; b < BANKS; b++) begin
                r_count[b] <= '0;
                r_map[b]   <= '0;
            end
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (pop) begin
                        r_bank_idx <= head_bank;
                        r_tile     <= i_item.tile;
                        r_base     <= head_base;
                        r_cnt      <= head_cnt;
                        r_cmp_idx  <= '0;
                        if (i_item.oor) begin
                            r_strobe       <= 1'b1;
                            r_tile_index   <= '0;
                            r_status       <= tdt_pkg::ST_FULL;
                            r_map_slot     <= '0;
                            r_unique_count <= '0;
                        end else if (head_cnt != '0) begin
                            r_state <= S_SEARCH;
                        end else begin
                            r_count[head_bank] <= CNT_W'(1);
                            r_map[head_bank]   <= map_nxt;
                            r_strobe           <= 1'b1;
                            r_tile_index       <= '0;
                            r_status           <= tdt_pkg::ST_NEW;
                            r_map_slot         <= tdt_pkg::SLOT_OUT_W'(map_cur);
                            r_unique_count     <= tdt_pkg::UCNT_OUT_W'(1);
                        end
                    end
                end
                S_SEARCH: begin
                    priority if (cmp_hit) begin
                        r_state           <= S_IDLE;
                        r_map[r_bank_idx] <= map_nxt;
                        r_strobe          <= 1'b1;
                        r_tile_index      <= tdt_pkg::IDX_OUT_W'(r_cmp_idx);
                        r_status          <= tdt_pkg::ST_MATCH;
                        r_map_slot        <= tdt_pkg::SLOT_OUT_W'(map_cur);
                        r_unique_count    <= tdt_pkg::UCNT_OUT_W'(r_cnt);
                    end else if (cmp_last) begin
                        r_state           <= S_IDLE;
                        r_map[r_bank_idx] <= map_nxt;
                        r_strobe          <= 1'b1;
                        r_map_slot        <= tdt_pkg::SLOT_OUT_W'(map_cur);
                        if (r_cnt == CNT_W'(TILES_PER_BANK)) begin
                            r_tile_index   <= '0;
                            r_status       <= tdt_pkg::ST_FULL;
                            r_unique_count <= tdt_pkg::UCNT_OUT_W'(r_cnt);
                        end else begin
                            r_count[r_bank_idx] <= r_cnt + 1'b1;
                            r_tile_index        <= tdt_pkg::IDX_OUT_W'(r_cnt);
                            r_status            <= tdt_pkg::ST_NEW;
                            r_unique_count      <= tdt_pkg::UCNT_OUT_W'(r_cnt + 1'b1);
                        end
                    end else begin
                        r_cmp_idx <= r_cmp_idx + 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
